// ----- rtl/tbcd_pkg.sv -----
// shared types and constants of the text or binary command deframer
`default_nettype none

package tbcd_pkg;

  // default command buffer depth in bytes (supported range 2 to 64)
  localparam int CMD_BYTES_DEF = 64;

  // byte count width, holds the full buffer depth
  localparam int CNT_W  = 7;
  // buffer address width of the write transfer, covers the largest depth
  localparam int BUF_AW = 6;

  // descriptor queue depth between front and back
  localparam int Q_DEPTH = 2;

  localparam logic [7:0] CHAR_C  = 8'h43;
  localparam logic [7:0] CHAR_B  = 8'h42;
  localparam logic [7:0] CHAR_L  = 8'h4C;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_LISTEN = 2'd2
  } kind_e;

  // one framed command as handed from front to back
  typedef struct packed {
    kind_e            kind;
    logic [CNT_W-1:0] count;
  } desc_t;

  // write into the command buffer
  typedef struct packed {
    logic              en;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

endpackage

`default_nettype wire

// ----- rtl/tbcd_fifo.sv -----
// short descriptor queue between the framing front and the replay back
`default_nettype none

module tbcd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tbcd_pkg::desc_t desc_i,
  output logic           full_o,
  input  logic           pop_i,
  output tbcd_pkg::desc_t desc_o,
  output logic           empty_o
);
  import tbcd_pkg::*;

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  desc_t         store_q [Q_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign desc_o  = store_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= desc_i;
    end
  end

  // the front only pushes when there is room
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("descriptor pushed into a full queue");

endmodule

`default_nettype wire

// ----- rtl/tbcd_front.sv -----
// framing front: classifies received bytes and fills the command buffer
`default_nettype none

module tbcd_front #(
  parameter int CMD_BYTES = tbcd_pkg::CMD_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [7:0]        rx_byte_i,
  output logic              q_push_o,
  output tbcd_pkg::desc_t   q_desc_o,
  input  logic              q_full_i,
  input  logic              release_i,
  output tbcd_pkg::buf_wr_t wr_o
);
  import tbcd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TEXT    = 3'd1,
    PH_BLEN    = 3'd2,
    PH_BDATA   = 3'd3,
    PH_DISCARD = 3'd4
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             lock_q, lock_d;

  logic             acc, eol;
  logic [CNT_W-1:0] cnt_inc;

  // buffer is held from a stored command until replay has read it back
  assign full_o  = q_full_i || lock_q;
  assign acc     = push_i && !full_o;
  assign eol     = (rx_byte_i == CHAR_LF) || (rx_byte_i == CHAR_CR);
  assign cnt_inc = cnt_q + 1'b1;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    lock_d   = lock_q && !release_i;
    q_push_o = 1'b0;
    q_desc_o = '{kind: KIND_LISTEN, count: '0};
    wr_o     = '{en: 1'b0, addr: cnt_q[BUF_AW-1:0], data: rx_byte_i};
    if (acc) begin
      unique case (phase_q)
        PH_TEXT: begin
          if (eol) begin
            q_push_o = 1'b1;
            q_desc_o = '{kind: (cnt_q == '0) ? KIND_EMPTY : KIND_DATA, count: cnt_q};
            lock_d   = (cnt_q != '0);
            phase_d  = PH_IDLE;
          end else begin
            wr_o.en = 1'b1;
            cnt_d   = cnt_inc;
            if (cnt_inc >= CNT_W'(CMD_BYTES)) begin
              phase_d = PH_DISCARD;
            end
          end
        end
        PH_BLEN: begin
          if (rx_byte_i > 8'(CMD_BYTES)) begin
            phase_d = PH_IDLE;
          end else if (rx_byte_i == '0) begin
            q_push_o = 1'b1;
            q_desc_o = '{kind: KIND_EMPTY, count: '0};
            phase_d  = PH_IDLE;
          end else begin
            rem_d   = rx_byte_i[CNT_W-1:0];
            phase_d = PH_BDATA;
          end
        end
        PH_BDATA: begin
          wr_o.en = 1'b1;
          cnt_d   = cnt_inc;
          rem_d   = rem_q - 1'b1;
          if (rem_q == CNT_W'(1)) begin
            q_push_o = 1'b1;
            q_desc_o = '{kind: KIND_DATA, count: cnt_inc};
            lock_d   = 1'b1;
            phase_d  = PH_IDLE;
          end
        end
        PH_DISCARD: begin
          if (eol) begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          // idle, and any stray code behaves as idle
          phase_d = PH_IDLE;
          if (rx_byte_i == CHAR_C) begin
            phase_d = PH_TEXT;
            cnt_d   = '0;
          end else if (rx_byte_i == CHAR_B) begin
            phase_d = PH_BLEN;
            cnt_d   = '0;
            rem_d   = '0;
          end else if (rx_byte_i == CHAR_L) begin
            q_push_o = 1'b1;
            q_desc_o = '{kind: KIND_LISTEN, count: '0};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      lock_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      lock_q  <= lock_d;
    end
  end

  // a held buffer only follows a finished command, so framing is idle
  a_lock_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_q |-> (phase_q == PH_IDLE))
    else $error("buffer held while framing a command");

  // text framing never sits on a full buffer
  a_text_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TEXT) |-> (cnt_q < CNT_W'(CMD_BYTES)))
    else $error("text command past buffer end");

endmodule

`default_nettype wire

// ----- rtl/tbcd_back.sv -----
// replay back: command buffer memory and the result register
`default_nettype none

module tbcd_back #(
  parameter int CMD_BYTES = tbcd_pkg::CMD_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tbcd_pkg::buf_wr_t wr_i,
  input  tbcd_pkg::desc_t   q_desc_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  output logic              release_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [1:0]        kind_o,
  output logic [7:0]        cmd_byte_o,
  output logic              last_o
);
  import tbcd_pkg::*;

  localparam int AW = $clog2(CMD_BYTES);

  logic [7:0]       mem_q [CMD_BYTES];
  logic [7:0]       rdata_q;

  logic             out_vld_q, out_vld_d;
  kind_e            out_kind_q, out_kind_d;
  logic             out_last_q, out_last_d;
  logic             active_q, active_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic             release_q, release_d;

  logic             out_free, rd_en;
  logic [AW-1:0]    rd_addr;
  logic [CNT_W-1:0] idx_inc;

  assign out_free  = !out_vld_q || pop_i;
  assign idx_inc   = idx_q + 1'b1;
  assign empty_o   = !out_vld_q;
  assign kind_o    = out_kind_q;
  assign last_o    = out_last_q;
  assign cmd_byte_o = (out_kind_q == KIND_DATA) ? rdata_q : '0;
  assign release_o = release_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_kind_d = out_kind_q;
    out_last_d = out_last_q;
    active_d   = active_q;
    idx_d      = idx_q;
    n_d        = n_q;
    release_d  = 1'b0;
    q_pop_o    = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = idx_q[AW-1:0];
    if (active_q && out_free) begin
      // next stored byte of the command being replayed
      rd_en      = 1'b1;
      out_vld_d  = 1'b1;
      out_kind_d = KIND_DATA;
      out_last_d = (idx_inc == n_q);
      idx_d      = idx_inc;
      if (idx_inc == n_q) begin
        active_d  = 1'b0;
        release_d = 1'b1;
      end
    end else if (!active_q && out_free && !q_empty_i) begin
      q_pop_o    = 1'b1;
      out_vld_d  = 1'b1;
      out_kind_d = q_desc_i.kind;
      out_last_d = 1'b1;
      if (q_desc_i.kind == KIND_DATA) begin
        rd_en      = 1'b1;
        rd_addr    = '0;
        out_last_d = (q_desc_i.count == CNT_W'(1));
        idx_d      = CNT_W'(1);
        n_d        = q_desc_i.count;
        active_d   = (q_desc_i.count != CNT_W'(1));
        release_d  = (q_desc_i.count == CNT_W'(1));
      end
    end else if (pop_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      out_kind_q <= KIND_EMPTY;
      out_last_q <= 1'b0;
      active_q   <= 1'b0;
      idx_q      <= '0;
      n_q        <= '0;
      release_q  <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      out_kind_q <= out_kind_d;
      out_last_q <= out_last_d;
      active_q   <= active_d;
      idx_q      <= idx_d;
      n_q        <= n_d;
      release_q  <= release_d;
    end
  end

  // command buffer, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // replay never reads past the stored length
  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (idx_q < n_q))
    else $error("replay index past command length");

  // the buffer release is never asserted twice in a row, it follows the last read
  a_release_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    release_q |=> !release_q)
    else $error("buffer released twice in a row");

endmodule

`default_nettype wire

// ----- rtl/text_or_binary_command_deframer.sv -----
// top level of the text or binary command deframer
`default_nettype none

// throughput: one received byte per cycle while a command is being framed and the descriptor queue is not full
// input stalls from the byte that completes a data command until its last
//   stored byte has been read from the buffer
// replay gives one result per cycle while results are taken, from the registered-read buffer memory
// after the completing transfer the descriptor is stored in the queue, then the first byte enters the result register
// reset: asynchronous, active low; framing idle, queue and result register empty, buffer left as is

module text_or_binary_command_deframer #(
  parameter int CMD_BYTES = tbcd_pkg::CMD_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input side, a transfer when push is high and full is low
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  // result side, a transfer when pop is high and empty is low
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [7:0] cmd_byte_o,
  output logic       last_o
);
  import tbcd_pkg::*;

  // front to queue
  logic    q_push, q_full;
  desc_t   q_desc_in;
  // queue to back
  logic    q_pop, q_empty;
  desc_t   q_desc_out;
  // buffer write from front, buffer release from back
  buf_wr_t buf_wr;
  logic    buf_release;

  // framing: classifies bytes, fills the buffer, emits command descriptors
  tbcd_front #(
    .CMD_BYTES (CMD_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .rx_byte_i (rx_byte_i),
    .q_push_o  (q_push),
    .q_desc_o  (q_desc_in),
    .q_full_i  (q_full),
    .release_i (buf_release),
    .wr_o      (buf_wr)
  );

  // decouples framing from replay so each side stalls on its own
  tbcd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (q_desc_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .desc_o  (q_desc_out),
    .empty_o (q_empty)
  );

  // replay: reads the buffer back and drives the result register
  tbcd_back #(
    .CMD_BYTES (CMD_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (buf_wr),
    .q_desc_i   (q_desc_out),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .release_o  (buf_release),
    .empty_o    (empty),
    .pop_i      (pop),
    .kind_o     (kind_o),
    .cmd_byte_o (cmd_byte_o),
    .last_o     (last_o)
  );

endmodule

`default_nettype wire
